### hw/rtl/matrix3_inverse_normal_unit_macros.svh
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3_INVERSE_NORMAL_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_NORMAL_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/m3i_pkg.sv
// Types and constants of the 3x3 matrix inverse unit.
package m3i_pkg;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned COF_W     = 64;
  localparam int unsigned DET_W     = 98;
  localparam int unsigned DMAG_W    = 97;
  localparam int unsigned NUM_ELEM  = 9;
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned LANE_LAT  = DIV_STEPS + 2;
  localparam int unsigned PRE_LAT   = 5;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } den_t;

  localparam elem_t SAT_POS = 32'sh7FFF_FFFF;
  localparam elem_t SAT_NEG = 32'sh8000_0000;

  // cofactor m = e[PA_X]*e[PA_Y] - e[PB_X]*e[PB_Y], element index = row*3+col
  localparam logic [3:0] PA_X [NUM_ELEM] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam logic [3:0] PA_Y [NUM_ELEM] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam logic [3:0] PB_X [NUM_ELEM] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam logic [3:0] PB_Y [NUM_ELEM] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

endpackage

### hw/rtl/m3i_cofactor.sv
// Two-stage cofactor (adjugate) lanes: products, then differences.
module m3i_cofactor (
  input  logic          clk_i,
  input  logic          en_i,
  input  m3i_pkg::elem_t e_i   [m3i_pkg::NUM_ELEM],
  output m3i_pkg::cof_t  adj_o [m3i_pkg::NUM_ELEM],
  output m3i_pkg::elem_t row_o [3]
);
  import m3i_pkg::*;

  cof_t  pa_q [NUM_ELEM];
  cof_t  pb_q [NUM_ELEM];
  cof_t  adj_q [NUM_ELEM];
  elem_t row1_q [3];
  elem_t row2_q [3];

  for (genvar m = 0; m < NUM_ELEM; m++) begin : g_lane
    cof_t pa_d, pb_d;
    assign pa_d = e_i[PA_X[m]] * e_i[PA_Y[m]];
    assign pb_d = e_i[PB_X[m]] * e_i[PB_Y[m]];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[m]  <= pa_d;
        pb_q[m]  <= pb_d;
        adj_q[m] <= pa_q[m] - pb_q[m];
      end
    end
    assign adj_o[m] = adj_q[m];
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row1_q[j] <= e_i[j];
        row2_q[j] <= row1_q[j];
      end
    end
    assign row_o[j] = row2_q[j];
  end

endmodule

### hw/rtl/m3i_det.sv
// Two-stage determinant: split 32x64 products, then sum of three terms.
module m3i_det (
  input  logic           clk_i,
  input  logic           en_i,
  input  m3i_pkg::elem_t row_i [3],
  input  m3i_pkg::cof_t  cof_i [3],
  output m3i_pkg::det_t  det_o
);
  import m3i_pkg::*;

  logic signed [63:0] ph_q [3];
  logic signed [64:0] pl_q [3];
  det_t               det_q;

  for (genvar j = 0; j < 3; j++) begin : g_part
    logic signed [63:0] ph_d;
    logic signed [64:0] pl_d;
    assign ph_d = row_i[j] * $signed(cof_i[j][63:32]);
    assign pl_d = row_i[j] * $signed({1'b0, cof_i[j][31:0]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ph_q[j] <= ph_d;
        pl_q[j] <= pl_d;
      end
    end
  end

  det_t det_d;
  assign det_d = (DET_W'(ph_q[0]) <<< 32) + DET_W'(pl_q[0])
               + (DET_W'(ph_q[1]) <<< 32) + DET_W'(pl_q[1])
               + (DET_W'(ph_q[2]) <<< 32) + DET_W'(pl_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_d;
    end
  end

  assign det_o = det_q;

endmodule

### hw/rtl/m3i_div_lane.sv
// One divider lane: pipelined restoring division, rounding and saturation.
module m3i_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  m3i_pkg::cof_t  cof_i,
  input  m3i_pkg::den_t  den_i,
  output m3i_pkg::elem_t res_o
);
  import m3i_pkg::*;

  localparam int unsigned SHIFT = 2 * FRAC_BITS;
  localparam int unsigned NUM_W = COF_W + SHIFT;
  localparam int unsigned CMP_W = DMAG_W + DIV_STEPS;

  // setup: magnitude, sign, overflow check (quotient >= 2^33)
  logic [COF_W-1:0]        cm;
  logic [NUM_W-1:0]        num;
  logic [NUM_W+DMAG_W-1:0] numx;
  logic                    ovf_d;

  assign cm    = cof_i[COF_W-1] ? COF_W'(-cof_i) : COF_W'(cof_i);
  assign num   = {cm, SHIFT'(0)};
  assign numx  = {DMAG_W'(0), num};
  assign ovf_d = CMP_W'(num) >= {den_i.mag, DIV_STEPS'(0)};

  logic [DMAG_W-1:0]    r_q   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] lo_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_q   [DIV_STEPS+1];
  logic [DMAG_W-1:0]    d_q   [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];
  logic                 ovf_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= numx[DIV_STEPS +: DMAG_W];
      lo_q[0]  <= num[DIV_STEPS-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_i.mag;
      neg_q[0] <= cof_i[COF_W-1] ^ den_i.neg;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DMAG_W:0] rt, rn;
    logic            ge;
    assign rt = {r_q[k], lo_q[k][DIV_STEPS-1]};
    assign ge = rt >= {1'b0, d_q[k]};
    assign rn = ge ? rt - {1'b0, d_q[k]} : rt;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= rn[DMAG_W-1:0];
        lo_q[k+1]  <= {lo_q[k][DIV_STEPS-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][DIV_STEPS-2:0], ge};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // round half away from zero, then saturate in the sign's direction
  logic               rnd;
  logic [DIV_STEPS:0] qr;
  elem_t              res_d, res_q;

  assign rnd = {r_q[DIV_STEPS], 1'b0} >= {1'b0, d_q[DIV_STEPS]};
  assign qr  = {1'b0, q_q[DIV_STEPS]} + (DIV_STEPS+1)'(rnd);

  always_comb begin
    if (!neg_q[DIV_STEPS]) begin
      if (ovf_q[DIV_STEPS] || qr > (DIV_STEPS+1)'(SAT_POS)) res_d = SAT_POS;
      else res_d = qr[ELEM_W-1:0];
    end else begin
      if (ovf_q[DIV_STEPS] || qr > (DIV_STEPS+1)'(unsigned'(SAT_NEG))) res_d = SAT_NEG;
      else res_d = ELEM_W'(~qr[ELEM_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/matrix3_inverse_normal_unit.sv
// Top level of the 3x3 fixed-point matrix inverse / normal matrix unit.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | to unit   | in_valid_i / in_stall_o | a_r0c0_i .. a_r2c2_i
//  out     | from unit | out_valid_o/out_stall_i | b_r0c0_o .. b_r2c2_o, singular_o
//  cfg     | to unit   | cfg_we_i                | cfg_wdata_i (transpose_result)
//
// One item per cycle while in_stall_o is low; a result reaches out_valid_o through 41
// register stages (2 cofactor, 2 determinant, 1 magnitude, 35 divider lane, 1 output).
// The 33-step divider pipeline in each of the nine lanes sets the latency.
// Reset clears the valid chain, the output valid and the config bit.
// A stalled output only holds the pipe once its last stage holds an item;
// until then new items keep entering behind the waiting result.
module matrix3_inverse_normal_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  m3i_pkg::elem_t a_r0c0_i,
  input  m3i_pkg::elem_t a_r0c1_i,
  input  m3i_pkg::elem_t a_r0c2_i,
  input  m3i_pkg::elem_t a_r1c0_i,
  input  m3i_pkg::elem_t a_r1c1_i,
  input  m3i_pkg::elem_t a_r1c2_i,
  input  m3i_pkg::elem_t a_r2c0_i,
  input  m3i_pkg::elem_t a_r2c1_i,
  input  m3i_pkg::elem_t a_r2c2_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output m3i_pkg::elem_t b_r0c0_o,
  output m3i_pkg::elem_t b_r0c1_o,
  output m3i_pkg::elem_t b_r0c2_o,
  output m3i_pkg::elem_t b_r1c0_o,
  output m3i_pkg::elem_t b_r1c1_o,
  output m3i_pkg::elem_t b_r1c2_o,
  output m3i_pkg::elem_t b_r2c0_o,
  output m3i_pkg::elem_t b_r2c1_o,
  output m3i_pkg::elem_t b_r2c2_o,
  output logic           singular_o
);
  import m3i_pkg::*;
  `include "matrix3_inverse_normal_unit_macros.svh"

  localparam int unsigned TOT_LAT  = PRE_LAT + LANE_LAT;
  localparam int unsigned SING_LEN = LANE_LAT + 1;

  // ---------------- flow control ----------------
  logic               tr_q;
  logic [TOT_LAT-1:0] v_q;
  logic               out_valid_q;
  logic               hold, pipe_en, last_v;

  assign last_v     = v_q[TOT_LAT-1];
  assign hold       = out_valid_q & out_stall_i & last_v;
  assign pipe_en    = ~hold;
  assign in_stall_o = hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q <= 1'b0;
    end else if (cfg_we_i) begin
      tr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[TOT_LAT-2:0], in_valid_i};
    end
  end

  // ---------------- cofactors and determinant ----------------
  elem_t e_in [NUM_ELEM];
  assign e_in[0] = a_r0c0_i;
  assign e_in[1] = a_r0c1_i;
  assign e_in[2] = a_r0c2_i;
  assign e_in[3] = a_r1c0_i;
  assign e_in[4] = a_r1c1_i;
  assign e_in[5] = a_r1c2_i;
  assign e_in[6] = a_r2c0_i;
  assign e_in[7] = a_r2c1_i;
  assign e_in[8] = a_r2c2_i;

  cof_t  adj2 [NUM_ELEM];
  elem_t row2 [3];
  cof_t  det_cof [3];
  det_t  det4;

  m3i_cofactor u_cofactor (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .e_i   (e_in),
    .adj_o (adj2),
    .row_o (row2)
  );

  // first-row expansion uses the first column of the adjugate
  assign det_cof[0] = adj2[0];
  assign det_cof[1] = adj2[3];
  assign det_cof[2] = adj2[6];

  m3i_det u_det (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .row_i (row2),
    .cof_i (det_cof),
    .det_o (det4)
  );

  // adjugate rides along the two determinant stages, then the magnitude stage
  cof_t adj3_q [NUM_ELEM];
  cof_t adj4_q [NUM_ELEM];
  cof_t adj5_q [NUM_ELEM];
  den_t den_q;
  logic [SING_LEN-1:0] sing_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      adj3_q <= adj2;
      adj4_q <= adj3_q;
      adj5_q <= adj4_q;
      den_q.neg <= det4[DET_W-1];
      den_q.mag <= det4[DET_W-1] ? DMAG_W'(-det4) : DMAG_W'(det4);
      sing_q    <= {sing_q[SING_LEN-2:0], det4 == '0};
    end
  end

  // ---------------- nine divider lanes ----------------
  elem_t res [NUM_ELEM];

  for (genvar m = 0; m < NUM_ELEM; m++) begin : g_lane
    m3i_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .cof_i (adj5_q[m]),
      .den_i (den_q),
      .res_o (res[m])
    );
  end

  // ---------------- merge: transpose select, singular zeroing ----------------
  elem_t b_q [NUM_ELEM];
  logic  sing_out_q;

  for (genvar m = 0; m < NUM_ELEM; m++) begin : g_merge
    localparam int unsigned MT = (m % 3) * 3 + (m / 3);
    elem_t b_d;
    always_comb begin
      if (sing_q[SING_LEN-1]) b_d = '0;
      else if (tr_q)          b_d = res[MT];
      else                    b_d = res[m];
    end
    always_ff @(posedge clk_i) begin
      if (pipe_en && last_v) begin
        b_q[m] <= b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && last_v) begin
      sing_out_q <= sing_q[SING_LEN-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en && last_v) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign singular_o  = sing_out_q;
  assign b_r0c0_o    = b_q[0];
  assign b_r0c1_o    = b_q[1];
  assign b_r0c2_o    = b_q[2];
  assign b_r1c0_o    = b_q[3];
  assign b_r1c1_o    = b_q[4];
  assign b_r1c2_o    = b_q[5];
  assign b_r2c0_o    = b_q[6];
  assign b_r2c1_o    = b_q[7];
  assign b_r2c2_o    = b_q[8];

  // ---------------- assertions ----------------
  `M3I_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i && last_v,
    "input stalled without a blocked result at the pipe end")
  `M3I_ASSERT_NXT(a_drain, out_valid_o && !out_stall_i && !last_v, !out_valid_o,
    "output valid after drain with no item at the pipe end")
  `M3I_ASSERT_IMP(a_sing_zero, out_valid_o && singular_o,
    b_r0c0_o == 0 && b_r1c1_o == 0 && b_r2c2_o == 0 && b_r0c2_o == 0 && b_r2c0_o == 0,
    "singular result carries nonzero entries")

endmodule

### tb/matrix3_inverse_checker.sv
// Checker for the matrix inverse unit: predicts each result and compares it with the output.
`timescale 1ns / 1ps

module matrix3_inverse_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  m3i_pkg::elem_t a_i [9],
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  m3i_pkg::elem_t b_i [9],
  input  logic           singular_i,
  output int unsigned    pending_o,
  output int unsigned    errors_o
);
  import m3i_pkg::*;

  localparam int unsigned FRAC = 16;

  typedef struct {
    elem_t elem [9];
    logic  singular;
  } inverse_t;

  inverse_t   expected_q [$];
  logic       transpose_q;
  int unsigned err_cnt;

  assign errors_o  = err_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Rounded, saturated cof * 2^(2*FRAC) / det
  function automatic elem_t scaled_quotient(input logic signed [63:0] cof,
                                            input logic [127:0] dmag, input logic dneg);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic         neg;
    num = cof[63] ? 128'(-cof) : 128'(cof);
    neg = cof[63] != dneg;
    if (num == 0) return '0;
    num = num << (2 * FRAC);
    quo = num / dmag;
    rem = num % dmag;
    if (rem >= dmag - rem) quo = quo + 1;
    if (!neg) return (quo > 128'h7FFF_FFFF) ? SAT_POS : elem_t'(quo[31:0]);
    if (quo > 128'h8000_0000) return SAT_NEG;
    return elem_t'(-quo[31:0]);
  endfunction

  function automatic inverse_t invert(input elem_t a [9], input logic tr);
    inverse_t              res;
    logic signed [63:0]    e [9];
    logic signed [63:0]    adj [9];
    logic signed [127:0]   det;
    logic [127:0]          dmag;
    for (int i = 0; i < 9; i++) e[i] = 64'(a[i]);
    adj[0] = e[4] * e[8] - e[7] * e[5];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[3] * e[2] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[6] * e[4];
    adj[7] = e[6] * e[1] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[3] * e[1];
    det = 128'(e[0]) * 128'(adj[0]) + 128'(e[1]) * 128'(adj[3])
        + 128'(e[2]) * 128'(adj[6]);
    res.singular = (det == 0);
    dmag = det[127] ? -det : det;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        elem_t v;
        v = res.singular ? '0 : scaled_quotient(adj[r*3+c], dmag, det[127]);
        if (tr) res.elem[c*3+r] = v;
        else res.elem[r*3+c] = v;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q = 1'b0;
      err_cnt     = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(singular_i), '0);
        end else begin
          inverse_t want;
          want = expected_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (b_i[i] !== want.elem[i])
              report_mismatch($sformatf("b[%0d]", i), b_i[i], want.elem[i]);
          if (singular_i !== want.singular)
            report_mismatch("singular", 32'(singular_i), 32'(want.singular));
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(invert(a_i, transpose_q));
      if (cfg_we_i) transpose_q = cfg_wdata_i;
      pending_o = expected_q.size();
    end
  end

endmodule

### tb/tb.sv
// Testbench top: stimulus, reset, clock and verdict for the matrix inverse unit.
`timescale 1ns / 1ps

module tb;
  import m3i_pkg::*;

  localparam int unsigned DRAIN  = 60;      // outlasts the pipe latency
  localparam int unsigned LIMIT  = 400000;  // cycles, several times the slowest run
  localparam elem_t       ONE    = 32'sh0001_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic        singular;
  elem_t       mat [9];
  elem_t       res [9];
  int unsigned pending;
  int unsigned errors;
  bit          idling;   // random gaps and stalls on both sides
  int unsigned cycles;

  matrix3_inverse_normal_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .a_r0c0_i   (mat[0]),
    .a_r0c1_i   (mat[1]),
    .a_r0c2_i   (mat[2]),
    .a_r1c0_i   (mat[3]),
    .a_r1c1_i   (mat[4]),
    .a_r1c2_i   (mat[5]),
    .a_r2c0_i   (mat[6]),
    .a_r2c1_i   (mat[7]),
    .a_r2c2_i   (mat[8]),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .b_r0c0_o   (res[0]),
    .b_r0c1_o   (res[1]),
    .b_r0c2_o   (res[2]),
    .b_r1c0_o   (res[3]),
    .b_r1c1_o   (res[4]),
    .b_r1c2_o   (res[5]),
    .b_r2c0_o   (res[6]),
    .b_r2c1_o   (res[7]),
    .b_r2c2_o   (res[8]),
    .singular_o (singular)
  );

  matrix3_inverse_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .a_i        (mat),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .b_i        (res),
    .singular_i (singular),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("FAIL matrix3_inverse_normal_unit");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Present one matrix at the falling edge and hold it until accepted.
  task automatic send_matrix(input elem_t m [9]);
    bit taken;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    mat      = m;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    in_valid = 1'b0;
  endtask

  // Block is idle once nothing is outstanding and the pipe has emptied.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_transpose(input logic value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_diag(input elem_t d0, input elem_t d1, input elem_t d2);
    elem_t m [9];
    m = '{default: '0};
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    send_matrix(m);
  endtask

  // Random matrix of a chosen flavor: most are well conditioned with small
  // entries, the rest full-range noise, singular or near-diagonal.
  task automatic send_random();
    elem_t m [9];
    int    kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0, 1:    m[i] = elem_t'($urandom);
        2:       m[i] = elem_t'($urandom_range(0, 32'h3F)) - 32'sd32;
        default: m[i] = elem_t'($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      endcase
    end
    if (kind == 3) begin
      // duplicated row: determinant is exactly zero
      for (int c = 0; c < 3; c++) m[6 + c] = m[c];
    end else if (kind == 4) begin
      // strong diagonal, off-diagonal tiny
      for (int i = 0; i < 9; i++)
        if (i % 4 != 0) m[i] = elem_t'($urandom_range(0, 15)) - 32'sd8;
    end
    send_matrix(m);
  endtask

  initial begin
    elem_t m [9];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    idling    = 1'b0;
    mat       = '{default: '0};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: identity, zero, extremes, singular and saturating cases.
    send_diag(ONE, ONE, ONE);
    send_diag('0, '0, '0);
    send_diag(32'sd1, 32'sd1, 32'sd1);                   // huge inverse, saturate high
    send_diag(-32'sd1, 32'sd1, 32'sd1);                  // saturate low
    send_diag(SAT_POS, SAT_POS, SAT_POS);                // result rounds to two LSBs
    send_diag(SAT_NEG, SAT_NEG, SAT_NEG);
    send_diag(3 * ONE, 3 * ONE, -3 * ONE);               // thirds, negative det
    send_diag(2 * ONE, 32'sh0000_8000, -ONE);
    m = '{default: SAT_POS};
    send_matrix(m);                                      // all rows equal
    m = '{default: SAT_NEG};
    send_matrix(m);
    m = '{SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_POS, SAT_POS, SAT_NEG};
    send_matrix(m);
    m = '{ONE, 2 * ONE, 3 * ONE, '0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, '0};
    send_matrix(m);                                      // asymmetric, checks ordering
    m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
    send_matrix(m);                                      // singular, dependent rows
    m = '{32'sd2, 32'sd1, '0, 32'sd1, 32'sd2, 32'sd1, '0, 32'sd1, 32'sd2};
    send_matrix(m);                                      // tiny entries, saturating mix

    write_transpose(1'b1);
    m = '{ONE, 2 * ONE, 3 * ONE, '0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, '0};
    send_matrix(m);
    send_diag(32'sd1, -32'sd1, SAT_NEG);

    // Random phases with both transpose settings and idling on.
    idling = 1'b1;
    for (int i = 0; i < 400; i++) send_random();
    write_transpose(1'b0);
    for (int i = 0; i < 300; i++) send_random();
    // Sender holds off until every outstanding result is back.
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 250; i++) send_random();
    write_transpose(1'b1);
    for (int i = 0; i < 150; i++) send_random();
    // Last stretch back to back at full rate.
    idling = 1'b0;
    for (int i = 0; i < 150; i++) send_random();

    wait_idle();
    if (errors == 0) begin
      $display("PASS matrix3_inverse_normal_unit");
    end else begin
      $display("FAIL matrix3_inverse_normal_unit");
    end
    $finish;
  end

endmodule
